// File: design/mtd_pkg.sv
// Shared types and constants for the MIDI track event decoder.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int unsigned DeltaW   = 28;
  localparam int unsigned MetaValW = 32;

  localparam logic [6:0] META_END     = 7'd47;
  localparam logic [6:0] META_TEMPO   = 7'd81;
  localparam logic [6:0] META_TIMESIG = 7'd88;

  localparam logic [7:0] STATUS_META  = 8'hff;
  localparam logic [7:0] STATUS_SYS   = 8'hf0;
  localparam logic [7:0] NOTE_ON_MASK = 8'h8f;

  typedef enum logic [3:0] {
    KIND_NOTE_OFF    = 4'd0,
    KIND_NOTE_ON     = 4'd1,
    KIND_POLY_TOUCH  = 4'd2,
    KIND_CONTROL     = 4'd3,
    KIND_PROGRAM     = 4'd4,
    KIND_PRESSURE    = 4'd5,
    KIND_BEND        = 4'd6,
    KIND_META        = 4'd7,
    KIND_END         = 4'd8,
    KIND_NO_RUNNING  = 4'd9,
    KIND_UNSUPPORTED = 4'd10
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    kind_e               event_kind;
    logic [3:0]          channel;
    logic [6:0]          first_data;
    logic [6:0]          second_data;
    logic [DeltaW-1:0]   delta_ticks;
    logic [6:0]          meta_type;
    logic [MetaValW-1:0] meta_value;
  } out_item_t;

endpackage

// File: design/mtd_in_stage.sv
// Input register of the MIDI track event decoder.
// Depends on mtd_pkg for the input transaction type.
`timescale 1ns / 1ps

module mtd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtd_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output logic              valid_o,
  output mtd_pkg::in_item_t data_o
);
  import mtd_pkg::*;

  logic     valid_q;
  in_item_t data_q;

  assign in_stall_o = valid_q && !take_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

// File: design/mtd_parser.sv
// Track byte parser: delta time, running status, channel message and meta event decoding.
// Holds the parse state; depends on mtd_pkg for types and constants.
`timescale 1ns / 1ps

module mtd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mtd_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output mtd_pkg::out_item_t res_o
);
  import mtd_pkg::*;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_DATA1  = 3'd2,
    PH_DATA2  = 3'd3,
    PH_MTYPE  = 3'd4,
    PH_MLEN   = 3'd5,
    PH_MDATA  = 3'd6
  } phase_e;

  phase_e              phase_q, phase_d, phase_c;
  logic [DeltaW-1:0]   delta_q, delta_d, delta_c;
  logic [7:0]          rs_q, rs_d, rs_c;
  logic [6:0]          held_q, held_d, held_c;
  logic [6:0]          mtype_q, mtype_d, mtype_c;
  logic [DeltaW-1:0]   left_q, left_d, left_c;
  logic [MetaValW-1:0] mval_q, mval_d, mval_c;
  logic                halted_q, halted_d, halted_c;
  logic [2:0]          taken_q, taken_d, taken_c;

  logic [7:0]          b;
  logic                data1_now;
  logic                two_data;
  logic                chan_ev;
  logic [6:0]          ev_d1, ev_d2;
  logic [7:0]          ev_st;
  logic                meta_ev;
  logic [DeltaW-1:0]   left_dec;
  logic [2:0]          limit;

  assign b = item_i.data_byte;

  always_comb begin
    phase_c  = phase_q;
    delta_c  = delta_q;
    rs_c     = rs_q;
    held_c   = held_q;
    mtype_c  = mtype_q;
    left_c   = left_q;
    mval_c   = mval_q;
    halted_c = halted_q;
    taken_c  = taken_q;
    if (item_i.track_start) begin
      phase_c  = PH_DELTA;
      delta_c  = '0;
      rs_c     = '0;
      held_c   = '0;
      mtype_c  = '0;
      left_c   = '0;
      mval_c   = '0;
      halted_c = 1'b0;
      taken_c  = '0;
    end

    phase_d  = phase_c;
    delta_d  = delta_c;
    rs_d     = rs_c;
    held_d   = held_c;
    mtype_d  = mtype_c;
    left_d   = left_c;
    mval_d   = mval_c;
    halted_d = halted_c;
    taken_d  = taken_c;

    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.event_kind  = KIND_NOTE_OFF;
    res_o.delta_ticks = delta_c;

    two_data  = (rs_c[7:4] != 4'hc) && (rs_c[7:4] != 4'hd);
    data1_now = 1'b0;
    chan_ev   = 1'b0;
    ev_d1     = '0;
    ev_d2     = '0;
    meta_ev   = 1'b0;
    left_dec  = left_c - DeltaW'(1);
    limit     = (mtype_c == META_TEMPO) ? 3'd3 : 3'd4;

    if (!halted_c) begin
      case (phase_c)
        PH_STATUS: begin
          if (b[7]) begin
            if (b == STATUS_META) begin
              phase_d = PH_MTYPE;
            end else if (b >= STATUS_SYS) begin
              res_valid_o      = 1'b1;
              res_o.event_kind = KIND_UNSUPPORTED;
              halted_d         = 1'b1;
            end else begin
              rs_d    = b;
              phase_d = PH_DATA1;
            end
          end else if (rs_c == '0) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = KIND_NO_RUNNING;
            halted_d         = 1'b1;
          end else begin
            data1_now = 1'b1;
          end
        end
        PH_DATA1: begin
          data1_now = 1'b1;
        end
        PH_DATA2: begin
          chan_ev = 1'b1;
          ev_d1   = held_c;
          ev_d2   = b[6:0];
        end
        PH_MTYPE: begin
          mtype_d = b[6:0];
          left_d  = '0;
          mval_d  = '0;
          taken_d = '0;
          phase_d = PH_MLEN;
        end
        PH_MLEN: begin
          left_d = {left_c[DeltaW-8:0], b[6:0]};
          if (!b[7]) begin
            if (left_d == '0) begin
              meta_ev = 1'b1;
            end else begin
              phase_d = PH_MDATA;
            end
          end
        end
        PH_MDATA: begin
          if (taken_c < limit) begin
            mval_d  = {mval_c[MetaValW-9:0], b};
            taken_d = taken_c + 3'd1;
          end
          left_d = left_dec;
          if (left_dec == '0) begin
            meta_ev = 1'b1;
          end
        end
        default: begin
          delta_d = {delta_c[DeltaW-8:0], b[6:0]};
          phase_d = b[7] ? PH_DELTA : PH_STATUS;
        end
      endcase
    end

    if (data1_now) begin
      if (two_data) begin
        held_d  = b[6:0];
        phase_d = PH_DATA2;
      end else begin
        chan_ev = 1'b1;
        ev_d1   = b[6:0];
        ev_d2   = '0;
      end
    end

    ev_st = rs_c;
    if (rs_c[7:4] == 4'h9 && ev_d2 == '0) begin
      ev_st = rs_c & NOTE_ON_MASK;
    end

    if (chan_ev) begin
      res_valid_o       = 1'b1;
      res_o.event_kind  = (ev_st[7:4] == 4'he) ? KIND_BEND : kind_e'(4'(ev_st[7:4] - 4'h8));
      res_o.channel     = ev_st[3:0];
      res_o.first_data  = ev_d1;
      res_o.second_data = two_data ? ev_d2 : 7'd0;
    end

    if (meta_ev) begin
      res_valid_o      = 1'b1;
      res_o.event_kind = (mtype_c == META_END) ? KIND_END : KIND_META;
      res_o.meta_type  = mtype_c;
      res_o.meta_value = (mtype_c == META_TEMPO || mtype_c == META_TIMESIG) ? mval_d : '0;
      if (mtype_c == META_END) begin
        halted_d = 1'b1;
      end
    end

    if (res_valid_o) begin
      delta_d = '0;
      phase_d = PH_DELTA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      delta_q  <= '0;
      rs_q     <= '0;
      held_q   <= '0;
      mtype_q  <= '0;
      left_q   <= '0;
      mval_q   <= '0;
      halted_q <= 1'b0;
      taken_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      delta_q  <= delta_d;
      rs_q     <= rs_d;
      held_q   <= held_d;
      mtype_q  <= mtype_d;
      left_q   <= left_d;
      mval_q   <= mval_d;
      halted_q <= halted_d;
      taken_q  <= taken_d;
    end
  end

`ifndef SYNTHESIS
  a_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.event_kind == KIND_END) |=> halted_q)
    else $error("end of track did not halt the parser");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && step_i && !item_i.track_start |-> !res_valid_o)
    else $error("halted parser produced an event");

  a_delta_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o |=> delta_q == '0)
    else $error("delta time not cleared after an event");

  a_note_on_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.event_kind == KIND_NOTE_ON) |-> res_o.second_data != '0)
    else $error("note on with zero velocity");
`endif

endmodule

// File: design/mtd_out_stage.sv
// Result register of the MIDI track event decoder.
// Depends on mtd_pkg for the result transaction type.
`timescale 1ns / 1ps

module mtd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mtd_pkg::out_item_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mtd_pkg::out_item_t out_data_o
);
  import mtd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

// File: design/midi_track_event_decoder_top.sv
// MIDI track event decoder, top level.
// Takes one track byte per input transaction and returns decoded events.
// Input channel: in_valid_i / in_stall_o carry data_byte and track_start.
// Set track_start on the first byte of each track; it clears running
// status, parse phase and the halt after an error or end of track.
// Output channel: out_valid_o / out_stall_i carry one event per complete
// message (channel message, meta event, or error kind).
// The byte that completes an event is held in the input register; the event
// is then loaded into the result register, which drives the output.
// Throughput: one byte per cycle unless the receiver stalls; the parse
// state updates in a single step between the input and result registers.
// Bytes that complete no message produce no output transaction.
// While the receiver stalls, the result register holds its event; the
// input register holds the next byte and in_stall_o rises once it is full.
// Reset empties both registers and returns the parser to the delta-time
// phase with no running status.
`timescale 1ns / 1ps

module midi_track_event_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mtd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mtd_pkg::out_item_t out_data_o
);
  import mtd_pkg::*;

  logic      s1_valid;
  in_item_t  s1_data;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  assign advance = s1_valid && out_free;

  mtd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (advance),
    .valid_o    (s1_valid),
    .data_o     (s1_data)
  );

  mtd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_data),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mtd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
